/* rtl/kpht_pkg.sv */
// Shared types and constants for the kerning pair hash table.
package kpht_pkg;

    // Width of the raw hash left*19 + right*7 for 16-bit codes.
    localparam int HASH_W = 21;

    localparam logic [4:0] HASH_MUL_LEFT  = 5'd19;
    localparam logic [2:0] HASH_MUL_RIGHT = 3'd7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_LIMIT    = 2'd2;
    localparam logic [1:0] ST_ZERO_KEY = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic        [15:0] left_code;
        logic        [15:0] right_code;
        logic signed [7:0]  kern_value;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] value_out;
        logic        [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic        [15:0] left_code;
        logic        [15:0] right_code;
        logic signed [7:0]  kern_value;
    } entry_t;

endpackage

/* rtl/kerning_pair_hash_table_top.sv */
// Kerning pair hash table: open addressing with quadratic probing in one memory.
// Flow: accept, an address state, then one check per slot examined, result
// registered; a table size that is not a power of two adds the reduce and fold states for the hash.
// An item is accepted only in the idle state, so a new one waits until the last result is loaded.
// A zero left code goes straight to the output state and does not touch the table.
// After reset a clearing pass writes every slot empty, with s_ready low.
module kerning_pair_hash_table_top
    import kpht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16384,
    parameter int MAX_PROBES    = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int ADDR_W    = $clog2(TABLE_ENTRIES);
    localparam int PC_W      = $clog2(MAX_PROBES + 1);
    localparam bit IS_POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int RECIP_SH  = HASH_W + ADDR_W;
    localparam int RECIP_W   = HASH_W + 1;
    localparam int PROD_W    = HASH_W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + longint'(TABLE_ENTRIES) - 1)
                               / longint'(TABLE_ENTRIES);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
    localparam logic [HASH_W-1:0]  SIZE_H   = HASH_W'(TABLE_ENTRIES);
    localparam logic [ADDR_W:0]    SIZE_EXT = (ADDR_W + 1)'(TABLE_ENTRIES);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_PROBE  = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [2:0] S_FOLD   = 3'd6;

    function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= SIZE_EXT) begin
            sum = sum - SIZE_EXT;
        end
        return sum[ADDR_W-1:0];
    endfunction

    entry_t pair_mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    in_item_t          item_reg, item_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] quo_reg, quo_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] sq_reg, sq_next;
    logic [ADDR_W-1:0] delta_reg, delta_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    entry_t            mem_wdata;
    logic              out_free, load_out, found, is_match;
    out_item_t         load_data;
    logic [HASH_W-1:0] hash_val;
    logic [ADDR_W-1:0] idx_step;
    logic [PROD_W-1:0] recip_prod;
    logic [HASH_W-1:0] fold_prod;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign out_free = !out_valid_reg || m_ready;

    assign hash_val = HASH_W'(s_data.left_code) * HASH_W'(HASH_MUL_LEFT)
                    + HASH_W'(s_data.right_code) * HASH_W'(HASH_MUL_RIGHT);

    // The rounded-up reciprocal gives the exact quotient for every hash that fits HASH_W bits.
    assign recip_prod = PROD_W'(h_reg) * PROD_W'(RECIP);
    assign fold_prod  = quo_reg * SIZE_H;

    assign is_match = (rd_data_reg.left_code == item_reg.left_code)
                   && (rd_data_reg.right_code == item_reg.right_code);
    assign found    = (rd_data_reg.left_code == 16'd0) || is_match;
    assign idx_step = mod_add(idx_reg, sq_reg);

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        item_next      = item_reg;
        h_next         = h_reg;
        quo_next       = quo_reg;
        idx_next       = idx_reg;
        sq_next        = sq_reg;
        delta_next     = delta_reg;
        pc_next        = pc_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;
        load_out       = 1'b0;
        load_data      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(TABLE_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    if (s_data.left_code == 16'd0) begin
                        res_next.value_out = '0;
                        res_next.status    = (s_data.cmd == CMD_INSERT) ? ST_ZERO_KEY
                                                                        : ST_MISS;
                        state_next         = S_OUT;
                    end else begin
                        h_next     = hash_val;
                        state_next = IS_POW2 ? S_PROBE : S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                quo_next   = HASH_W'(recip_prod >> RECIP_SH);
                state_next = S_FOLD;
            end
            S_FOLD: begin
                // The remainder is the hash less the quotient times the table size.
                h_next     = h_reg - fold_prod;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                mem_re     = 1'b1;
                mem_raddr  = h_reg[ADDR_W-1:0];
                idx_next   = h_reg[ADDR_W-1:0];
                sq_next    = ADDR_W'(1);
                delta_next = ADDR_W'(3);
                pc_next    = PC_W'(1);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (found) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                        if (item_reg.cmd == CMD_INSERT) begin
                            mem_we               = 1'b1;
                            mem_wdata.left_code  = item_reg.left_code;
                            mem_wdata.right_code = item_reg.right_code;
                            mem_wdata.kern_value = item_reg.kern_value;
                            load_data.status     = ST_OK;
                        end else if (rd_data_reg.left_code == 16'd0) begin
                            load_data.status = ST_MISS;
                        end else begin
                            load_data.value_out = rd_data_reg.kern_value;
                            load_data.status    = ST_OK;
                        end
                    end
                end else if (pc_reg == PC_W'(MAX_PROBES)) begin
                    if (out_free) begin
                        load_out         = 1'b1;
                        load_data.status = ST_LIMIT;
                        state_next       = S_IDLE;
                    end
                end else begin
                    // The next slot is read at once, without leaving the check state.
                    mem_re     = 1'b1;
                    mem_raddr  = idx_step;
                    idx_next   = idx_step;
                    sq_next    = mod_add(sq_reg, delta_reg);
                    delta_next = mod_add(delta_reg, ADDR_W'(2));
                    pc_next    = pc_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    load_data  = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = load_data;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
            out_data_next  = out_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pair_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= pair_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        h_reg        <= h_next;
        quo_reg      <= quo_next;
        idx_reg      <= idx_next;
        sq_reg       <= sq_next;
        delta_reg    <= delta_next;
        pc_reg       <= pc_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // The table is written only by the clearing pass or by an insert that ends its probe.
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_CLEAR) || (state_reg == S_CHECK && item_reg.cmd == CMD_INSERT))
        else $error("table written outside clearing or insert");

    // An insert never stores a key that reads back as an empty slot.
    a_no_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == S_CHECK) |-> mem_wdata.left_code != 16'd0)
        else $error("insert stored a zero left code");

    // The probe count stays within the limit and the slot index within the table.
    a_probe_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHECK |-> pc_reg != '0 && pc_reg <= PC_W'(MAX_PROBES)
                                 && {1'b0, idx_reg} < SIZE_EXT)
        else $error("probe count or slot index out of range");

    // A result is only loaded when the output register is free to take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !out_valid_reg || m_ready)
        else $error("pending result overwritten");

endmodule

/* tb/kerning_pair_hash_table_top_tb.sv */
// Self-checking testbench for the kerning pair hash table, with a behavioural table model.
`timescale 1ns / 1ps

module kerning_pair_hash_table_top_tb;
    import kpht_pkg::*;

    localparam int TABLE_ENTRIES  = 16384;
    localparam int MAX_PROBES     = 32;
    localparam int CLUSTER_SPAN   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 100000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    entry_t    kern_pairs [TABLE_ENTRIES];
    in_item_t  pair_ops_q [$];
    out_item_t kern_results_q [$];
    logic [31:0] noise_keys [$];
    out_item_t want;

    int cl_left  [3];
    int cl_right [3];
    int idle_pct     = 30;
    int holds_asked  = 0;
    int holds_done   = 0;
    int stall_cycles = 0;
    int quiet_cycles = 0;
    int fail_cnt     = 0;

    kerning_pair_hash_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_PROBES   (MAX_PROBES)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Applies one insert or lookup to the table copy and returns the result it yields.
    function automatic out_item_t apply_pair_op(input in_item_t op);
        out_item_t res;
        int slot;
        bit found;
        res.value_out = '0;
        res.status    = ST_OK;
        found         = 1'b0;
        slot = (int'(op.left_code) * int'(HASH_MUL_LEFT)
                + int'(op.right_code) * int'(HASH_MUL_RIGHT)) % TABLE_ENTRIES;
        if (op.left_code == 16'd0) begin
            res.status = (op.cmd == CMD_INSERT) ? ST_ZERO_KEY : ST_MISS;
        end else begin
            for (int k = 1; k <= MAX_PROBES && !found; k++) begin
                if (kern_pairs[slot].left_code == 16'd0 ||
                    (kern_pairs[slot].left_code == op.left_code &&
                     kern_pairs[slot].right_code == op.right_code)) begin
                    found = 1'b1;
                end else begin
                    slot = (slot + (k * k) % TABLE_ENTRIES) % TABLE_ENTRIES;
                end
            end
            if (!found) begin
                res.status = ST_LIMIT;
            end else if (op.cmd == CMD_INSERT) begin
                kern_pairs[slot].left_code  = op.left_code;
                kern_pairs[slot].right_code = op.right_code;
                kern_pairs[slot].kern_value = op.kern_value;
            end else if (kern_pairs[slot].left_code == 16'd0) begin
                res.status = ST_MISS;
            end else begin
                res.value_out = kern_pairs[slot].kern_value;
            end
        end
        return res;
    endfunction

    task automatic queue_op(input logic cmd, input logic [15:0] left_c,
                            input logic [15:0] right_c, input logic [7:0] value);
        in_item_t op;
        op.cmd        = cmd;
        op.left_code  = left_c;
        op.right_code = right_c;
        op.kern_value = value;
        pair_ops_q.push_back(op);
    endtask

    // Keys (L0 + 7t, R0 - 19t) share one home slot, so they pile up on one probe chain.
    task automatic queue_cluster_op(input logic cmd, input int c, input int t,
                                    input logic [7:0] value);
        queue_op(cmd, 16'(cl_left[c] + 7 * t), 16'(cl_right[c] - 19 * t), value);
    endtask

    task automatic queue_random_ops(input int count);
        int pick;
        logic [15:0] left_c;
        logic [15:0] right_c;
        logic [31:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_cluster_op(1'($urandom_range(0, 1)), $urandom_range(0, 2),
                                 $urandom_range(0, CLUSTER_SPAN), 8'($urandom_range(0, 255)));
            end else begin
                if (pick < 80 || noise_keys.size() == 0) begin
                    left_c  = 16'($urandom_range(1, 65535));
                    right_c = 16'($urandom_range(0, 65535));
                    noise_keys.push_back({left_c, right_c});
                end else if (pick < 95) begin
                    key     = noise_keys[$urandom_range(0, noise_keys.size() - 1)];
                    left_c  = key[31:16];
                    right_c = key[15:0];
                end else begin
                    left_c  = 16'd0;
                    right_c = 16'($urandom_range(0, 65535));
                end
                queue_op(1'($urandom_range(0, 1)), left_c, right_c,
                         8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pair_ops_q.size() != 0 || s_valid || kern_results_q.size() != 0)
            @(negedge aclk);
    endtask

    // Sender: presents queued items, with random gaps, and records what each accepted item yields.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                kern_results_q.push_back(apply_pair_op(s_data));
            if (!s_valid || s_ready) begin
                if (pair_ops_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pair_ops_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, long hold-offs on request, and the result check.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (kern_results_q.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d",
                             $time, m_data.value_out, m_data.status);
                    fail_cnt++;
                end else begin
                    want = kern_results_q.pop_front();
                    if (m_data.value_out !== want.value_out) begin
                        $display("%0t: value_out expected %0d got %0d",
                                 $time, want.value_out, m_data.value_out);
                        fail_cnt++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, m_data.status);
                        fail_cnt++;
                    end
                end
            end
            if (holds_asked != holds_done) begin
                holds_done   <= holds_asked;
                stall_cycles <= HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else if (stall_cycles > 0) begin
                stall_cycles <= stall_cycles - 1;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Watchdog: ends the run with FAIL if no item is accepted and no result taken within WATCHDOG_LIMIT.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            kern_pairs[i] = '0;
        for (int c = 0; c < 3; c++) begin
            cl_left[c]  = $urandom_range(1, 65535 - 7 * CLUSTER_SPAN);
            cl_right[c] = $urandom_range(19 * CLUSTER_SPAN, 65535);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, overwrite, zero keys, and three keys that share left code and home.
        queue_op(CMD_LOOKUP, 16'd1, 16'd0, 8'h55);
        queue_op(CMD_INSERT, 16'd1, 16'd0, 8'sd127);
        queue_op(CMD_LOOKUP, 16'd1, 16'd0, 8'h00);
        queue_op(CMD_INSERT, 16'hFFFF, 16'hFFFF, -8'sd128);
        queue_op(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 8'hFF);
        queue_op(CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'sd5);
        queue_op(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 8'h00);
        queue_op(CMD_LOOKUP, 16'hFFFF, 16'hFFFE, 8'h00);
        queue_op(CMD_INSERT, 16'd0, 16'd1234, 8'sd33);
        queue_op(CMD_LOOKUP, 16'd0, 16'd1234, 8'h00);
        queue_op(CMD_INSERT, 16'd0, 16'd0, -8'sd1);
        queue_op(CMD_LOOKUP, 16'd0, 16'd0, 8'h00);
        queue_op(CMD_INSERT, 16'd1, 16'd16384, -8'sd7);
        queue_op(CMD_LOOKUP, 16'd1, 16'd16384, 8'h00);
        queue_op(CMD_LOOKUP, 16'd1, 16'd0, 8'h00);
        queue_op(CMD_LOOKUP, 16'd1, 16'd32768, 8'h00);

        // Fill one probe chain so that the next key with the same home runs out of probes.
        for (int t = 0; t < MAX_PROBES; t++)
            queue_cluster_op(CMD_INSERT, 0, t, 8'($urandom_range(0, 255)));
        queue_cluster_op(CMD_INSERT, 0, MAX_PROBES, 8'($urandom_range(0, 255)));
        queue_cluster_op(CMD_LOOKUP, 0, MAX_PROBES, 8'h00);
        queue_cluster_op(CMD_LOOKUP, 0, 0, 8'h00);
        queue_cluster_op(CMD_LOOKUP, 0, MAX_PROBES - 1, 8'h00);
        wait_drained();

        // The receiver stalls for a long stretch while the sender keeps offering items.
        queue_random_ops(150);
        holds_asked = holds_asked + 1;
        wait_drained();

        idle_pct = 0;
        queue_random_ops(100);
        wait_drained();

        idle_pct = 30;
        queue_random_ops(150);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_cnt == 0 && kern_results_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
